FILE: design/pfsd_pkg.sv
// Shared constants, codes and types of the pilot frame sync detector.
package pfsd_pkg;

  localparam int MAX_SYMBOLS_DEF = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int FACTOR_W   = 16;
  localparam int FRAC_BITS  = 14;
  localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);

  localparam int SUM_W = 40;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam int FRAME_W  = 6;
  localparam int SYM_W    = 5;
  localparam int STATUS_W = 2;

  localparam int QUEUE_DEPTH = 8;
  localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic KIND_PAIR  = 1'b0;
  localparam logic KIND_START = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_NONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CONFIRMED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISMATCH  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_CORRECTED = 2'd3;

  // Register index as decoded from paddr[2].
  localparam logic REG_SYNC_INPUT = 1'b0;
  localparam logic REG_FRAME_LEN  = 1'b1;

  localparam logic [FRAME_W-1:0] FRAME_LEN_RST = 6'd15;

  typedef struct packed {
    logic             kind;
    logic             last_pair;
    logic [SUM_W-1:0] term;
  } q_entry_t;

  typedef struct packed {
    logic               sync_input;
    logic [FRAME_W-1:0] frame_len;
    logic               clear_count;
  } cfg_t;

endpackage

FILE: design/pfsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfsd_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/pfsd_front.sv
// Front end: accepts beats and computes the saturated squared pilot error of each pair.
module pfsd_front #(
  parameter int SAMPLE_BITS = pfsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  kind,
  input  logic signed [SAMPLE_BITS-1:0]         first_re,
  input  logic signed [SAMPLE_BITS-1:0]         first_im,
  input  logic signed [SAMPLE_BITS-1:0]         second_re,
  input  logic signed [SAMPLE_BITS-1:0]         second_im,
  input  logic signed [pfsd_pkg::FACTOR_W-1:0]  factor_re,
  input  logic signed [pfsd_pkg::FACTOR_W-1:0]  factor_im,
  input  logic                                  last_pair,
  input  logic [pfsd_pkg::QLEVEL_W-1:0]         q_level,
  output logic                                  push,
  output pfsd_pkg::q_entry_t                    push_entry
);

  localparam int S   = SAMPLE_BITS;
  localparam int PRW = S + pfsd_pkg::FACTOR_W;
  localparam int CBW = PRW + 1;
  localparam int RW  = CBW - pfsd_pkg::FRAC_BITS;
  localparam int EW  = RW + 1;
  localparam int MW  = RW;
  localparam int SQW = 2 * MW;
  localparam int TW  = SQW + 1;
  localparam int XW  = (TW > pfsd_pkg::SUM_W) ? TW : pfsd_pkg::SUM_W + 1;
  localparam int UW  = pfsd_pkg::QLEVEL_W + 1;

  // Stage 0: input registers.
  logic                v0, k0, l0;
  logic signed [S-1:0] a_re0, a_im0, b_re0, b_im0;
  logic signed [pfsd_pkg::FACTOR_W-1:0] f_re0, f_im0;

  // Stage 1: partial products.
  logic                  v1, k1, l1;
  logic signed [PRW-1:0] p_rr1, p_ii1, p_ri1, p_ir1;
  logic signed [S-1:0]   b_re1, b_im1;

  // Stage 2: error magnitudes.
  logic          v2, k2, l2;
  logic [MW-1:0] mag_re2, mag_im2;

  // Stage 3: squares.
  logic           v3, k3, l3;
  logic [SQW-1:0] sq_re3, sq_im3;

  logic [UW-1:0]  used;
  logic           accept;

  logic signed [CBW-1:0] comb_re, comb_im, rnd_re, rnd_im;
  logic signed [EW-1:0]  err_re, err_im;
  logic [MW-1:0]         mag_re, mag_im;
  logic [XW-1:0]         term_x;

  // Credit check: every beat in flight has a queue slot reserved, so the pipe never stops.
  assign used = UW'(q_level) + UW'(v0) + UW'(v1) + UW'(v2) + UW'(v3);
  assign in_stall = (used >= UW'(pfsd_pkg::QUEUE_DEPTH));
  assign accept = in_valid && !in_stall;

  always_comb begin
    comb_re = CBW'(p_rr1) - CBW'(p_ii1);
    comb_im = CBW'(p_ri1) + CBW'(p_ir1);
    rnd_re  = (comb_re + CBW'(pfsd_pkg::ROUND_BIAS)) >>> pfsd_pkg::FRAC_BITS;
    rnd_im  = (comb_im + CBW'(pfsd_pkg::ROUND_BIAS)) >>> pfsd_pkg::FRAC_BITS;
    err_re  = EW'(rnd_re) - EW'(b_re1);
    err_im  = EW'(rnd_im) - EW'(b_im1);
    mag_re  = err_re[EW-1] ? MW'(-err_re) : MW'(err_re);
    mag_im  = err_im[EW-1] ? MW'(-err_im) : MW'(err_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      k0    <= kind;
      l0    <= last_pair;
      a_re0 <= first_re;
      a_im0 <= first_im;
      b_re0 <= second_re;
      b_im0 <= second_im;
      f_re0 <= factor_re;
      f_im0 <= factor_im;
    end
    k1    <= k0;
    l1    <= l0;
    p_rr1 <= a_re0 * f_re0;
    p_ii1 <= a_im0 * f_im0;
    p_ri1 <= a_re0 * f_im0;
    p_ir1 <= a_im0 * f_re0;
    b_re1 <= b_re0;
    b_im1 <= b_im0;
    k2      <= k1;
    l2      <= l1;
    mag_re2 <= mag_re;
    mag_im2 <= mag_im;
    k3     <= k2;
    l3     <= l2;
    sq_re3 <= mag_re2 * mag_re2;
    sq_im3 <= mag_im2 * mag_im2;
  end

  assign term_x = XW'(sq_re3) + XW'(sq_im3);

  assign push                 = v3;
  assign push_entry.kind      = k3;
  assign push_entry.last_pair = l3;
  assign push_entry.term      = (|term_x[XW-1:pfsd_pkg::SUM_W]) ? pfsd_pkg::SUM_MAX
                                                               : term_x[pfsd_pkg::SUM_W-1:0];

endmodule

FILE: design/pfsd_queue.sv
// Short flop-based queue between the front end and the back end.
module pfsd_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  pfsd_pkg::q_entry_t            push_entry,
  input  logic                          pop,
  output pfsd_pkg::q_entry_t            head,
  output logic                          empty,
  output logic [pfsd_pkg::QLEVEL_W-1:0] level
);

  localparam int PW = $clog2(pfsd_pkg::QUEUE_DEPTH);

  pfsd_pkg::q_entry_t slots [pfsd_pkg::QUEUE_DEPTH];
  logic [PW-1:0]      wr_ptr, rd_ptr;

  assign head  = slots[rd_ptr];
  assign empty = (level == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(pfsd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(pfsd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

FILE: design/pfsd_back.sv
// Back end: accumulates pair errors, keeps the frame history and decides the symbol number.
module pfsd_back #(
  parameter int MAX_SYMBOLS = pfsd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pfsd_pkg::cfg_t                cfg,
  input  logic                          q_empty,
  input  pfsd_pkg::q_entry_t            q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfsd_pkg::SYM_W-1:0]    symbol_number,
  output logic [pfsd_pkg::STATUS_W-1:0] sync_status
);

  localparam int CW  = $clog2(MAX_SYMBOLS);
  localparam int NW  = $clog2(MAX_SYMBOLS + 1);
  localparam int FW1 = pfsd_pkg::FRAME_W + 1;
  localparam int SW  = pfsd_pkg::SUM_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]             state;
  logic [SW-1:0]          sum;
  logic [CW-1:0]          cnt;
  logic                   bad_sync;
  logic                   acquiring;
  logic [CW-1:0]          wp;
  logic [MAX_SYMBOLS-1:0] hist_valid;
  logic [CW-1:0]          rd_addr, rd_pos;
  logic                   cmp_en, vld_q;
  logic [CW-1:0]          cmp_pos;
  logic [SW-1:0]          min_val;
  logic [CW-1:0]          min_idx;
  logic [pfsd_pkg::STATUS_W-1:0] status;

  logic [NW-1:0]  n_len, mid, target, cnt_inc;
  logic [CW-1:0]  cnt_wrap, wp_inc, rd_addr_inc, scan_start;
  logic [NW:0]    start_sum;
  logic [SW:0]    sum_wide;
  logic [SW-1:0]  sum_sat, ram_q, hist_val;
  logic           detect, hist_we;

  always_comb begin
    if (cfg.frame_len < pfsd_pkg::FRAME_W'(2)) begin
      n_len = NW'(2);
    end else if ({1'b0, cfg.frame_len} > FW1'(MAX_SYMBOLS)) begin
      n_len = NW'(MAX_SYMBOLS);
    end else begin
      n_len = NW'(cfg.frame_len);
    end
  end

  assign mid    = n_len >> 1;
  assign target = n_len - mid - 1'b1;

  assign cnt_inc  = NW'(cnt) + 1'b1;
  assign cnt_wrap = (cnt_inc >= n_len) ? '0 : CW'(cnt_inc);

  assign sum_wide = {1'b0, sum} + {1'b0, q_head.term};
  assign sum_sat  = sum_wide[SW] ? pfsd_pkg::SUM_MAX : sum_wide[SW-1:0];

  assign wp_inc      = (wp == CW'(MAX_SYMBOLS - 1)) ? '0 : wp + 1'b1;
  assign rd_addr_inc = (rd_addr == CW'(MAX_SYMBOLS - 1)) ? '0 : rd_addr + 1'b1;

  // The window starts n-1 entries behind the newest one, modulo the ring size.
  assign start_sum  = (NW+1)'(wp_inc) + (NW+1)'(MAX_SYMBOLS) - (NW+1)'(n_len) + 1'b1;
  assign scan_start = (start_sum >= (NW+1)'(MAX_SYMBOLS))
                      ? CW'(start_sum - (NW+1)'(MAX_SYMBOLS)) : CW'(start_sum);

  assign detect  = !cfg.sync_input && acquiring;
  assign q_pop   = (state == S_IDLE) && !q_empty;
  assign hist_we = q_pop && (q_head.kind == pfsd_pkg::KIND_PAIR) && q_head.last_pair && detect;

  // Entries never written read as saturated, so they never win the search.
  assign hist_val = vld_q ? ram_q : pfsd_pkg::SUM_MAX;

  pfsd_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_SYMBOLS)
  ) u_hist (
    .clk  (clk),
    .we   (hist_we),
    .waddr(wp_inc),
    .wdata(sum_sat),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sum        <= '0;
      cnt        <= '0;
      bad_sync   <= 1'b1;
      acquiring  <= 1'b0;
      wp         <= '0;
      hist_valid <= '0;
      cmp_en     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      cmp_en  <= (state == S_SCAN);
      cmp_pos <= rd_pos;
      vld_q   <= hist_valid[rd_addr];

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cmp_en && (hist_val < min_val)) begin
        min_val <= hist_val;
        min_idx <= cmp_pos;
      end

      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_head.kind == pfsd_pkg::KIND_START) begin
              cnt       <= '0;
              acquiring <= 1'b1;
            end else begin
              sum <= sum_sat;
              if (q_head.last_pair) begin
                if (detect) begin
                  wp                 <= wp_inc;
                  hist_valid[wp_inc] <= 1'b1;
                  rd_addr            <= scan_start;
                  rd_pos             <= '0;
                  min_val            <= pfsd_pkg::SUM_MAX;
                  min_idx            <= '0;
                  state              <= S_SCAN;
                end else begin
                  status <= pfsd_pkg::STATUS_NONE;
                  state  <= S_EMIT;
                end
              end
            end
          end
        end
        S_SCAN: begin
          rd_addr <= rd_addr_inc;
          rd_pos  <= rd_pos + 1'b1;
          if (rd_pos == CW'(n_len - 1'b1)) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (NW'(min_idx) == mid) begin
            if (NW'(cnt) == target) begin
              bad_sync <= 1'b0;
              status   <= pfsd_pkg::STATUS_CONFIRMED;
            end else if (bad_sync) begin
              cnt      <= CW'(target);
              bad_sync <= 1'b0;
              status   <= pfsd_pkg::STATUS_CORRECTED;
            end else begin
              bad_sync <= 1'b1;
              status   <= pfsd_pkg::STATUS_MISMATCH;
            end
          end else begin
            status <= pfsd_pkg::STATUS_NONE;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            symbol_number <= pfsd_pkg::SYM_W'(cnt);
            sync_status   <= status;
            cnt           <= cnt_wrap;
            sum           <= '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg.clear_count) begin
        cnt <= '0;
      end
    end
  end

endmodule

FILE: design/pilot_frame_sync_detector.sv
// Top level of the pilot frame sync detector: register port, front end, queue and back end.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+-------------------------------------------------
//  input    | in_valid / in_stall   | kind, first_re/im, second_re/im, factor_re/im,
//           |                       | last_pair
//  output   | out_valid / out_stall | symbol_number, sync_status
//  config   | psel, penable, pwrite | paddr, pwdata, prdata (pready tied high)
//
// The front end takes one beat per cycle while in_stall is low; its error term passes the
// input, product, magnitude and square registers before it enters the queue. The back end
// retires a pair that is not the last of its symbol without leaving its idle state.
// A last pair goes straight to emit without detection, and through scan, wait, decide and emit
// with it; one RAM read port lets the minimum scan read one entry a cycle over the frame length.
// Reset is synchronous; the history starts all saturated through per-entry valid bits.
// A stalled output holds its beat while the front end keeps filling the queue.
module pilot_frame_sync_detector #(
  parameter int MAX_SYMBOLS = pfsd_pkg::MAX_SYMBOLS_DEF,
  parameter int SAMPLE_BITS = pfsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 kind,
  input  logic signed [SAMPLE_BITS-1:0]        first_re,
  input  logic signed [SAMPLE_BITS-1:0]        first_im,
  input  logic signed [SAMPLE_BITS-1:0]        second_re,
  input  logic signed [SAMPLE_BITS-1:0]        second_im,
  input  logic signed [pfsd_pkg::FACTOR_W-1:0] factor_re,
  input  logic signed [pfsd_pkg::FACTOR_W-1:0] factor_im,
  input  logic                                 last_pair,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pfsd_pkg::SYM_W-1:0]           symbol_number,
  output logic [pfsd_pkg::STATUS_W-1:0]        sync_status,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pfsd_pkg::ADDR_W-1:0]          paddr,
  input  logic [pfsd_pkg::DATA_W-1:0]          pwdata,
  output logic [pfsd_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);

  logic                          sync_input;
  logic [pfsd_pkg::FRAME_W-1:0]  frame_len;
  logic                          cfg_wr;
  pfsd_pkg::cfg_t                cfg;

  logic                          push, q_pop, q_empty;
  pfsd_pkg::q_entry_t            push_entry, q_head;
  logic [pfsd_pkg::QLEVEL_W-1:0] q_level;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_input <= 1'b0;
      frame_len  <= pfsd_pkg::FRAME_LEN_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == pfsd_pkg::REG_SYNC_INPUT) begin
        sync_input <= pwdata[0];
      end else begin
        frame_len <= pwdata[pfsd_pkg::FRAME_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == pfsd_pkg::REG_FRAME_LEN) ? pfsd_pkg::DATA_W'(frame_len)
                                                         : pfsd_pkg::DATA_W'(sync_input);

  assign cfg.sync_input  = sync_input;
  assign cfg.frame_len   = frame_len;
  assign cfg.clear_count = cfg_wr && (paddr[2] == pfsd_pkg::REG_FRAME_LEN);

  pfsd_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .first_re  (first_re),
    .first_im  (first_im),
    .second_re (second_re),
    .second_im (second_im),
    .factor_re (factor_re),
    .factor_im (factor_im),
    .last_pair (last_pair),
    .q_level   (q_level),
    .push      (push),
    .push_entry(push_entry)
  );

  pfsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .level     (q_level)
  );

  pfsd_back #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .symbol_number(symbol_number),
    .sync_status  (sync_status)
  );

endmodule

FILE: design/pfsd_checker.sv
// Port-level checker for the pilot frame sync detector, bound to the top level.
module pfsd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [pfsd_pkg::SYM_W-1:0]    symbol_number,
  input logic [pfsd_pkg::STATUS_W-1:0] sync_status,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic                          pready,
  input logic [pfsd_pkg::ADDR_W-1:0]   paddr,
  input logic [pfsd_pkg::DATA_W-1:0]   pwdata,
  input logic [pfsd_pkg::DATA_W-1:0]   prdata
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(symbol_number) && $stable(sync_status))
    else $error("result beat changed while stalled");

  // Reset empties the whole path: no pending result and full input credit.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // A written frame length reads back on the following cycle.
  a_frame_len_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && (paddr[2] == pfsd_pkg::REG_FRAME_LEN)
    |=> !psel || pwrite || (paddr[2] != pfsd_pkg::REG_FRAME_LEN)
        || (prdata[pfsd_pkg::FRAME_W-1:0] == $past(pwdata[pfsd_pkg::FRAME_W-1:0])))
    else $error("frame length read back differs from the value written");

endmodule

bind pilot_frame_sync_detector pfsd_checker u_pfsd_checker (.*);
